// File: rtl/core/lkvt_pkg.sv
// ----------------------------------------------------------------------------
// lkvt_pkg: shared definitions for the linear key/value table
// Default parameters, operation and status codes, and the controller to
// datapath command bundle.
// ----------------------------------------------------------------------------
package lkvt_pkg;

    localparam int CAPACITY_DEF      = 64;
    localparam int KEY_BYTES_DEF     = 8;
    localparam int PAYLOAD_BYTES_DEF = 8;

    localparam int DATA_W  = 64;
    localparam int LEN_W   = 4;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int LIMIT_W = 7;

    localparam logic [LIMIT_W-1:0] CAP_LIMIT_RESET = 7'd64;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_GET    = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_DELETE = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // latch the masked key, compare mask and payload
        logic rd_en;      // read both stores at the read address
        logic wr_key;     // write the key store at the write address
        logic wr_pay;     // write the payload store at the write address
        logic shift_src;  // write data comes from the last read, not the item
        logic cap_pay;    // keep the payload just read as the result
        logic publish;    // move the result payload to the output register
    } t_cmd;

endpackage

// File: rtl/core/lkvt_datapath.sv
// ----------------------------------------------------------------------------
// lkvt_datapath: entry stores and compare logic
// Holds the key and payload memories, the latched item, the registered read
// port, the key comparator and the result payload registers.
// ----------------------------------------------------------------------------
module lkvt_datapath
    import lkvt_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int KEY_BYTES     = KEY_BYTES_DEF,
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic              i_clk,
    input  logic [DATA_W-1:0] i_key,
    input  logic [LEN_W-1:0]  i_key_length,
    input  logic [DATA_W-1:0] i_payload,
    input  logic [LEN_W-1:0]  i_payload_length,
    input  t_cmd              i_cmd,
    input  logic [IW-1:0]     i_rd_addr,
    input  logic [IW-1:0]     i_wr_addr,
    output logic              o_hit,
    output logic [DATA_W-1:0] o_payload_out
);

    localparam int KW = KEY_BYTES * 8;
    localparam int PW = PAYLOAD_BYTES * 8;

    logic [KW-1:0] r_key_mem [CAPACITY];
    logic [PW-1:0] r_pay_mem [CAPACITY];

    logic [KW-1:0]     r_key;
    logic [KW-1:0]     r_mask;
    logic [PW-1:0]     r_pay;
    logic [KW-1:0]     r_rd_key;
    logic [PW-1:0]     r_rd_pay;
    logic [PW-1:0]     r_res_pay;
    logic [DATA_W-1:0] r_out_pay;

    logic [LEN_W-1:0] klen;
    logic [LEN_W-1:0] plen;
    logic [KW-1:0]    key_mask;
    logic [PW-1:0]    pay_mask;
    logic [KW-1:0]    wr_key_data;
    logic [PW-1:0]    wr_pay_data;

    // Saturate the lengths and build byte masks
    always_comb begin
        klen = (i_key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : i_key_length;
        plen = (i_payload_length > LEN_W'(PAYLOAD_BYTES)) ?
               LEN_W'(PAYLOAD_BYTES) : i_payload_length;
        for (int b = 0; b < KEY_BYTES; b++) begin
            key_mask[8*b +: 8] = (LEN_W'(b) < klen) ? 8'hFF : 8'h00;
        end
        for (int b = 0; b < PAYLOAD_BYTES; b++) begin
            pay_mask[8*b +: 8] = (LEN_W'(b) < plen) ? 8'hFF : 8'h00;
        end
    end

    assign wr_key_data = i_cmd.shift_src ? r_rd_key : r_key;
    assign wr_pay_data = i_cmd.shift_src ? r_rd_pay : r_pay;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key     <= i_key[KW-1:0] & key_mask;
            r_mask    <= key_mask;
            r_pay     <= i_payload[PW-1:0] & pay_mask;
            r_res_pay <= '0;
        end else if (i_cmd.cap_pay) begin
            r_res_pay <= r_rd_pay;
        end
        if (i_cmd.publish) begin
            r_out_pay <= DATA_W'(r_res_pay);
        end
    end

    // Entry stores: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_key) begin
            r_key_mem[i_wr_addr] <= wr_key_data;
        end
        if (i_cmd.wr_pay) begin
            r_pay_mem[i_wr_addr] <= wr_pay_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_key <= r_key_mem[i_rd_addr];
            r_rd_pay <= r_pay_mem[i_rd_addr];
        end
    end

    assign o_hit         = ((r_rd_key ^ r_key) & r_mask) == '0;
    assign o_payload_out = r_out_pay;

endmodule

// File: rtl/core/lkvt_ctrl.sv
// ----------------------------------------------------------------------------
// lkvt_ctrl: sequencer for the linear key/value table
// Holds the entry count and capacity register, steps the scan and the
// shift-down, and owns the handshakes and the result status.
// ----------------------------------------------------------------------------
module lkvt_ctrl
    import lkvt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [LIMIT_W-1:0] o_entries_held,
    input  logic               i_hit,
    output t_cmd               o_cmd,
    output logic [IW-1:0]      o_rd_addr,
    output logic [IW-1:0]      o_wr_addr
);

    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state             r_state,       n_state;
    t_mode              r_mode,        n_mode;
    logic [CW-1:0]      r_count,       n_count;
    logic [LIMIT_W-1:0] r_cap,         n_cap;
    logic [CW-1:0]      r_ra,          n_ra;
    logic               r_rv,          n_rv;
    logic [IW-1:0]      r_ci,          n_ci;
    t_status            r_status,      n_status;
    logic               r_out_valid,   n_out_valid;
    t_status            r_out_status,  n_out_status;
    logic [LIMIT_W-1:0] r_out_entries, n_out_entries;

    logic    full;
    logic    issue;
    logic [LW-1:0] count_ext;

    assign count_ext = LW'(r_count);
    assign full      = (count_ext >= LW'(CAPACITY)) || (count_ext >= LW'(r_cap));
    assign issue     = r_ra < r_count;

    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_count       = r_count;
        n_cap         = r_cap;
        n_ra          = r_ra;
        n_rv          = r_rv;
        n_ci          = r_ci;
        n_status      = r_status;
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_entries = r_out_entries;
        o_cmd         = '0;
        o_rd_addr     = r_ra[IW-1:0];
        o_wr_addr     = r_count[IW-1:0];

        if (i_cfg_valid) begin
            n_cap = i_cfg_data;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_mode     = t_mode'(i_mode);
                    n_ra       = '0;
                    n_rv       = 1'b0;
                    if (t_mode'(i_mode) == MODE_INSERT) begin
                        if (full) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_INS;
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_MISSING;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_INS: begin
                o_cmd.wr_key = 1'b1;
                o_cmd.wr_pay = 1'b1;
                n_count      = r_count + 1'b1;
                n_status     = ST_OK;
                n_state      = S_DONE;
            end
            S_SCAN: begin
                if (r_rv && i_hit) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    case (r_mode)
                        MODE_GET: begin
                            o_cmd.cap_pay = 1'b1;
                        end
                        MODE_UPDATE: begin
                            o_cmd.wr_pay = 1'b1;
                            o_wr_addr    = r_ci;
                        end
                        MODE_DELETE: begin
                            // Pull the later entries down over the match
                            n_ra    = CW'(r_ci) + 1'b1;
                            n_rv    = 1'b0;
                            n_state = S_SHIFT;
                        end
                        default: begin
                        end
                    endcase
                end else if (r_rv && (CW'(r_ci) == r_count - 1'b1)) begin
                    n_status = ST_MISSING;
                    n_state  = S_DONE;
                end else if (issue) begin
                    o_cmd.rd_en = 1'b1;
                    n_ci        = r_ra[IW-1:0];
                    n_ra        = r_ra + 1'b1;
                    n_rv        = 1'b1;
                end else begin
                    n_rv = 1'b0;
                end
            end
            S_SHIFT: begin
                if (r_rv) begin
                    o_cmd.wr_key    = 1'b1;
                    o_cmd.wr_pay    = 1'b1;
                    o_cmd.shift_src = 1'b1;
                    o_wr_addr       = IW'(r_ci - 1'b1);
                end
                if (issue) begin
                    o_cmd.rd_en = 1'b1;
                    n_ci        = r_ra[IW-1:0];
                    n_ra        = r_ra + 1'b1;
                    n_rv        = 1'b1;
                end else begin
                    n_rv = 1'b0;
                    if (!r_rv) begin
                        n_count  = r_count - 1'b1;
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_out_status  = r_status;
                    n_out_entries = count_ext[LIMIT_W-1:0];
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap       <= CAP_LIMIT_RESET;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_rv        <= n_rv;
            r_out_valid <= n_out_valid;
        end
        r_mode        <= n_mode;
        r_ra          <= n_ra;
        r_ci          <= n_ci;
        r_status      <= n_status;
        r_out_status  <= n_out_status;
        r_out_entries <= n_out_entries;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_entries_held = r_out_entries;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_count) <= LW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("insert did not advance the entry count");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wr_key && o_cmd.rd_en) |-> (o_wr_addr != o_rd_addr))
        else $error("shift writes the entry it reads");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) || (r_state == S_SHIFT)) |-> (r_ra <= r_count))
        else $error("scan address past the last entry");

endmodule

// File: rtl/core/linear_key_value_table.sv
// An item that ends at once (full insert, lookup on an empty table) goes straight to the result;
// an insert writes its entry first. Get or update scans up to the matching entry; a miss scans
// all held entries. Delete scans to the match, then moves each later entry down one place.
// One item at a time; one entry per cycle is scanned or moved.
// Reset (synchronous, active low) empties the table and sets the capacity limit to 64.
// ----------------------------------------------------------------------------
// linear_key_value_table: packed key/payload table searched in order
// Insert appends, get/update/delete act on the lowest matching entry, delete
// closes the gap keeping order. Controller and datapath are separate modules.
// ----------------------------------------------------------------------------
module linear_key_value_table
    import lkvt_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int KEY_BYTES     = KEY_BYTES_DEF,
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [DATA_W-1:0]  i_key,
    input  logic [LEN_W-1:0]   i_key_length,
    input  logic [DATA_W-1:0]  i_payload,
    input  logic [LEN_W-1:0]   i_payload_length,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [DATA_W-1:0]  o_payload_out,
    output logic [LIMIT_W-1:0] o_entries_held,
    // capacity limit write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    t_cmd          cmd;
    logic          hit;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;

    // Sequencer: accepts an item while idle, walks the entries from index
    // zero, then shifts the tail down on a delete. The finished result sits
    // in the output register, so the next item is taken while it waits.
    lkvt_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_entries_held (o_entries_held),
        .i_hit          (hit),
        .o_cmd          (cmd),
        .o_rd_addr      (rd_addr),
        .o_wr_addr      (wr_addr)
    );

    // Datapath: stores, masking of the item, comparator and result payload.
    // Only entries below the count are ever read, so the stores need no
    // clearing after reset.
    lkvt_datapath #(
        .CAPACITY      (CAPACITY),
        .KEY_BYTES     (KEY_BYTES),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_key            (i_key),
        .i_key_length     (i_key_length),
        .i_payload        (i_payload),
        .i_payload_length (i_payload_length),
        .i_cmd            (cmd),
        .i_rd_addr        (rd_addr),
        .i_wr_addr        (wr_addr),
        .o_hit            (hit),
        .o_payload_out    (o_payload_out)
    );

endmodule

// File: tb/sv/linear_key_value_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_key_value_table_test: self-checking bench for the linear key table
// Drives insert, get, update and delete items against a cycle-free model of
// the table kept in the bench, under random idling on both channels, and
// checks every result in order. The capacity limit is rewritten between
// phases, including zero, one, the true capacity and values above it.
// ----------------------------------------------------------------------------
module linear_key_value_table_test;
    import lkvt_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int MAX_REPORTS = 200;

    typedef struct {
        t_status             status;
        logic [DATA_W-1:0]   payload;
        logic [LIMIT_W-1:0]  held;
    } table_result_t;

    // Clock, reset and every block input start at a known level
    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_in_valid       = 1'b0;
    logic [MODE_W-1:0]  i_mode           = '0;
    logic [DATA_W-1:0]  i_key            = '0;
    logic [LEN_W-1:0]   i_key_length     = '0;
    logic [DATA_W-1:0]  i_payload        = '0;
    logic [LEN_W-1:0]   i_payload_length = '0;
    logic               i_out_stall      = 1'b0;
    logic               i_cfg_valid      = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_data       = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [STAT_W-1:0]  o_status;
    logic [DATA_W-1:0]  o_payload_out;
    logic [LIMIT_W-1:0] o_entries_held;
    logic               o_cfg_ready;

    // Bench copy of the table contents and the capacity register
    logic [DATA_W-1:0]  key_mem [CAPACITY];
    logic [DATA_W-1:0]  pay_mem [CAPACITY];
    int                 held_count;
    logic [LIMIT_W-1:0] cap_reg;

    table_result_t      pending_results[$];

    bit  idle_on = 1'b1;
    int  fail_count;
    int  cycle_count;
    int  items_sent;
    int  inserts_full;
    int  lookups_missed;
    int  lookups_hit;
    int  cap_writes;

    linear_key_value_table dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_key            (i_key),
        .i_key_length     (i_key_length),
        .i_payload        (i_payload),
        .i_payload_length (i_payload_length),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_payload_out    (o_payload_out),
        .o_entries_held   (o_entries_held),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Abort a hung run; the limit sits well above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("** linear_key_value_table: FAILED **");
            $finish;
        end
    end

    // Stall the result channel in about 11 percent of clocks while idling is on
    always @(posedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(99) < 11);
    end

    // Mask covering the lowest n bytes of a 64-bit word
    function automatic logic [DATA_W-1:0] byte_lane_mask(int n);
        if (n >= 8)
            return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // Work out the result of one operation and apply it to the bench table
    function automatic table_result_t apply_table_op(t_mode op, logic [DATA_W-1:0] key,
                                                     logic [LEN_W-1:0] klen_in,
                                                     logic [DATA_W-1:0] pay,
                                                     logic [LEN_W-1:0] plen_in);
        int                klen;
        int                plen;
        int                limit;
        int                hit;
        logic [DATA_W-1:0] kmask;
        logic [DATA_W-1:0] key_m;
        logic [DATA_W-1:0] pay_m;
        table_result_t     r;

        // Saturate both lengths to the stored widths
        klen  = (klen_in > 8) ? 8 : int'(klen_in);
        plen  = (plen_in > 8) ? 8 : int'(plen_in);
        kmask = byte_lane_mask(klen);
        key_m = key & kmask;
        pay_m = pay & byte_lane_mask(plen);
        limit = (cap_reg > CAPACITY) ? CAPACITY : int'(cap_reg);
        r.status  = ST_OK;
        r.payload = '0;

        if (op == MODE_INSERT) begin
            if (held_count >= limit) begin
                r.status = ST_FULL;
                inserts_full++;
            end else begin
                key_mem[held_count] = key_m;
                pay_mem[held_count] = pay_m;
                held_count++;
            end
        end else begin
            // Lowest-index entry whose leading klen bytes agree
            hit = -1;
            for (int i = 0; i < held_count; i++) begin
                if (hit < 0 && ((key_mem[i] ^ key_m) & kmask) == '0)
                    hit = i;
            end
            if (hit < 0) begin
                r.status = ST_MISSING;
                lookups_missed++;
            end else begin
                lookups_hit++;
                case (op)
                    MODE_GET: begin
                        r.payload = pay_mem[hit];
                    end
                    MODE_UPDATE: begin
                        pay_mem[hit] = pay_m;
                    end
                    default: begin
                        // Close the gap, keeping the order of later entries
                        for (int i = hit; i + 1 < held_count; i++) begin
                            key_mem[i] = key_mem[i + 1];
                            pay_mem[i] = pay_mem[i + 1];
                        end
                        held_count--;
                    end
                endcase
            end
        end
        r.held = held_count[LIMIT_W-1:0];
        return r;
    endfunction

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        table_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t unexpected result: status %0d payload %h held %0d", $time,
                         o_status, o_payload_out, o_entries_held);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t status: expected %0d actual %0d", $time,
                                 want.status, o_status);
                end
                if (o_payload_out !== want.payload) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t payload_out: expected %h actual %h", $time,
                                 want.payload, o_payload_out);
                end
                if (o_entries_held !== want.held) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t entries_held: expected %0d actual %0d", $time,
                                 want.held, o_entries_held);
                end
            end
        end
    end

    // Offer one item, with random idle cycles ahead of it, and hold it until taken
    task automatic send_item(t_mode op, logic [DATA_W-1:0] key, logic [LEN_W-1:0] klen,
                             logic [DATA_W-1:0] pay, logic [LEN_W-1:0] plen);
        while (idle_on && $urandom_range(99) < 11) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_mode           <= op;
        i_key            <= key;
        i_key_length     <= klen;
        i_payload        <= pay;
        i_payload_length <= plen;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_results.push_back(apply_table_op(op, key, klen, pay, plen));
        items_sent++;
    endtask

    // Drop valid and hold off until every predicted result has come back
    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the capacity limit with the table idle
    task automatic write_capacity(logic [LIMIT_W-1:0] value);
        wait_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cap_reg = value;
        cap_writes++;
    endtask

    function automatic logic [DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Key length mix: mostly in range, some zero, some above the key width
    function automatic logic [LEN_W-1:0] pick_key_length();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 16)
            return LEN_W'($urandom_range(15, 9));
        if (r < 40)
            return LEN_W'(1);
        return LEN_W'($urandom_range(8, 2));
    endfunction

    // One random item; lookups mostly aim at a stored key with junk past klen
    task automatic random_item(int insert_pct);
        t_mode             op;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] mask;
        logic [LEN_W-1:0]  klen;
        int                eff;
        int                idx;

        klen = pick_key_length();
        eff  = (klen > 8) ? 8 : int'(klen);
        mask = byte_lane_mask(eff);
        key  = rand_word();
        if ($urandom_range(99) < insert_pct) begin
            op = MODE_INSERT;
            // Short keys from a tiny pool build up duplicate entries
            if (klen == 1)
                key[7:0] = 8'($urandom_range(7));
        end else begin
            op = t_mode'($urandom_range(3, 1));
            if (held_count > 0 && $urandom_range(99) < 80) begin
                idx = $urandom_range(held_count - 1);
                key = (key_mem[idx] & mask) | (key & ~mask);
            end else if (klen == 1) begin
                key[7:0] = 8'($urandom_range(9));
            end
        end
        send_item(op, key, klen, rand_word(), LEN_W'($urandom_range(15)));
    endtask

    // ---------------------------------------------------------------- tests

    // Every lookup on a freshly reset table misses
    task automatic test_empty_table();
        send_item(MODE_GET, '0, 4'd8, '0, 4'd0);
        send_item(MODE_UPDATE, '1, 4'd8, '1, 4'd8);
        send_item(MODE_DELETE, rand_word(), 4'd0, '0, 4'd0);
    endtask

    // Insert at the field extremes, then hit, miss, update and delete
    task automatic test_insert_and_lookup();
        send_item(MODE_INSERT, '1, 4'd8, '1, 4'd8);
        send_item(MODE_INSERT, 64'h0123_4567_89AB_CDEF, 4'd3, 64'hFEDC_BA98_7654_3210, 4'd2);
        // Zero key length stores an all-zero key; oversized payload length saturates
        send_item(MODE_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, 4'd0, 64'h8000_0000_0000_0001, 4'd15);
        // Oversized key length saturates to the full key
        send_item(MODE_INSERT, 64'hA5A5_A5A5_A5A5_A5A5, 4'd15, 64'h0F0F_0F0F_0F0F_0F0F, 4'd9);
        // Zero key length on a lookup matches the lowest entry
        send_item(MODE_GET, rand_word(), 4'd0, '0, 4'd0);
        send_item(MODE_GET, 64'hFFFF_FFFF_FFAB_CDEF, 4'd3, '0, 4'd0);
        send_item(MODE_GET, 64'hFFFF_FFFF_FFAB_CDEF, 4'd8, '0, 4'd0);
        send_item(MODE_UPDATE, 64'h0000_0000_00AB_CDEF, 4'd3, '1, 4'd0);
        send_item(MODE_GET, 64'h0000_0000_00AB_CDEF, 4'd3, '0, 4'd0);
        send_item(MODE_UPDATE, 64'h0000_0000_00AB_CDEF, 4'd3, 64'hDEAD_BEEF_CAFE_F00D, 4'd15);
        send_item(MODE_GET, 64'h0000_0000_00AB_CDEF, 4'd15, '0, 4'd0);
        send_item(MODE_DELETE, 64'h1234_5678_90AB_CDEF, 4'd3, '0, 4'd0);
        send_item(MODE_GET, '0, 4'd8, '0, 4'd0);
        send_item(MODE_DELETE, '1, 4'd0, '0, 4'd0);
        send_item(MODE_GET, '1, 4'd8, '0, 4'd0);
    endtask

    // Limit below, at and above the count; zero and oversized register values
    task automatic test_capacity_limit();
        write_capacity(7'd2);
        send_item(MODE_INSERT, 64'h1111, 4'd2, 64'h2222, 4'd2);
        write_capacity(7'd0);
        send_item(MODE_INSERT, 64'h3333, 4'd2, 64'h4444, 4'd2);
        send_item(MODE_GET, 64'hA5, 4'd1, '0, 4'd0);
        send_item(MODE_DELETE, 64'hA5, 4'd1, '0, 4'd0);
        write_capacity(7'd127);
        send_item(MODE_INSERT, '0, 4'd8, '0, 4'd8);
    endtask

    // Random traffic under one capacity setting, with a full drain halfway
    task automatic test_random_traffic(logic [LIMIT_W-1:0] cap, int n_items, int insert_pct);
        write_capacity(cap);
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2 || $urandom_range(99) == 0)
                wait_results();
            random_item(insert_pct);
        end
    endtask

    // Insert-heavy traffic with the register above capacity, so the true ceiling bites
    task automatic test_table_full();
        test_random_traffic(7'd127, 250, 75);
    endtask

    // A long stretch with no idling on either side
    task automatic test_back_to_back();
        idle_on = 1'b0;
        test_random_traffic(7'd65, 200, 50);
        wait_results();
        idle_on = 1'b1;
    endtask

    initial begin
        held_count = 0;
        cap_reg    = CAP_LIMIT_RESET;
        // Hold reset low from the start, then release it for good
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_insert_and_lookup();
        test_capacity_limit();
        test_random_traffic(7'd64, 300, 50);
        test_table_full();
        test_random_traffic(7'd0, 100, 40);
        test_random_traffic(7'd1, 100, 50);
        test_random_traffic(LIMIT_W'($urandom_range(63, 2)), 300, 45);
        test_back_to_back();
        test_random_traffic(7'd64, 200, 30);

        // Let the slowest operation run out before judging
        wait_results();
        repeat (2 * CAPACITY + 8) @(posedge i_clk);

        $display("Covered %0d items over %0d capacity writes: %0d lookups hit, %0d missed,",
                 items_sent, cap_writes, lookups_hit, lookups_missed);
        $display("%0d inserts refused on a full table; %0d mismatches", inserts_full,
                 fail_count);
        if (fail_count == 0) begin
            $display("** linear_key_value_table: PASSED **");
        end else begin
            $display("** linear_key_value_table: FAILED **");
        end
        $finish;
    end

endmodule
